// ----- src/lottery_scheduler_macros.svh -----
// assertion macros for the lottery scheduler
`ifndef LOTTERY_SCHEDULER_MACROS_SVH
`define LOTTERY_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define LTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/lts_pkg.sv -----
// types and constants shared by the lottery scheduler files
`default_nettype none

package lts_pkg;

  // draw operand width
  localparam int RAND_W = 30;

  // ticket limits
  localparam int TICKETS_W = 7;
  localparam logic [TICKETS_W-1:0] START_TICKETS = 7'd5;
  localparam logic [TICKETS_W-1:0] MAX_TICKETS   = 7'd100;
  localparam logic [TICKETS_W-1:0] MIN_TICKETS   = 7'd1;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_LUCKY   = 2'd0;
  localparam logic [1:0] CFG_UNLUCKY = 2'd1;
  localparam logic [1:0] CFG_SLICE   = 2'd2;
  localparam logic [3:0]  LUCKY_RESET   = 4'd7;
  localparam logic [3:0]  UNLUCKY_RESET = 4'd14;
  localparam logic [15:0] SLICE_RESET   = 16'd200;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_NICE    = 2'd2,
    CMD_QUANTUM = 2'd3
  } lts_cmd_t;

  typedef struct packed {
    lts_cmd_t           cmd;
    logic [5:0]         slot;
    logic               is_system_proc;
    logic signed [7:0]  nice_delta;
    logic               keep_requester;
    logic [RAND_W-1:0]  random_value;
  } lts_in_t;

  typedef struct packed {
    logic [5:0]  target_slot;
    logic [3:0]  queue_number;
    logic [15:0] quantum;
    logic        last_of_run;
  } lts_out_t;

  // one slot table entry
  typedef struct packed {
    logic                 in_use;
    logic                 in_lottery;
    logic [TICKETS_W-1:0] tickets;
  } lts_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NICE_RD,
    ST_NICE_WR,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_EM_REQ,
    ST_EM_PREV,
    ST_EM_WIN,
    ST_EM_ONE
  } lts_state_t;

endpackage

`default_nettype wire

// ----- src/lts_rem_unit.sv -----
// restoring remainder unit, one quotient bit per cycle
`default_nettype none

module lts_rem_unit #(
  parameter int DIV_W = 15
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lts_pkg::RAND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]          divisor,
  output logic                           done,
  output logic [DIV_W-1:0]               remainder
);
  import lts_pkg::*;

  localparam int STEP_W = $clog2(RAND_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [RAND_W-1:0] dvd;
  logic [DIV_W:0]    trial;

  // shift in next dividend bit
  assign trial = {remainder, dvd[RAND_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(RAND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        remainder <= DIV_W'(trial - {1'b0, divisor});
      end else begin
        remainder <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/lottery_scheduler.sv -----
// lottery scheduler top level: slot table, draw sequencer and output register
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    lts_in_t
//   out       source     out_valid / out_ready  lts_out_t
//   cfg       sink       cfg_we                 cfg_addr, cfg_wdata
//
// start and stop write the slot in decode; nice reads it, then writes it back if it is in the
// lottery. a start result then waits for the output register. quantum expiry: a pipelined
// scan of the slot memory sums the tickets, the remainder unit runs one bit a cycle, a second
// scan finds the winner, then up to three results leave through the output register.
// synchronous reset clears all control state and the per-slot valid bits; no clearing pass.
// a stalled output only holds the sequencer in its emit states; input is taken when idle.
`default_nettype none

`include "lottery_scheduler_macros.svh"

module lottery_scheduler #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lts_pkg::lts_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lts_pkg::lts_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [15:0]      cfg_wdata
);
  import lts_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int TOT_W = $clog2(SLOT_COUNT * int'(MAX_TICKETS) + 1);
  localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(SLOT_COUNT);

  lts_state_t state, state_next;

  // configuration registers
  logic [3:0]  lucky_queue;
  logic [3:0]  unlucky_queue;
  logic [15:0] slice_len;

  // current item and draw registers
  lts_in_t          item;
  logic [IDX_W-1:0] req_idx;
  logic             has_req;
  logic             req_lot;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] which;
  logic [IDX_W:0]   cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] win_idx;
  logic [3:0]       em_queue;
  logic             winner_valid;
  logic [IDX_W-1:0] winner_slot;

  // slot memory
  lts_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  vld;
  lts_entry_t             mem_q;
  logic                   vld_q;
  lts_entry_t             rd_entry;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  lts_entry_t             mem_wd;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_ra;

  // handshake and output load
  logic             in_xfer;
  logic             out_free;
  logic             out_load;
  logic [IDX_W-1:0] ld_slot;
  logic [3:0]       ld_queue;
  logic             ld_last;

  // remainder unit
  logic             div_start;
  logic             div_done;
  logic [TOT_W-1:0] div_rem;

  // scan helpers
  logic             in_range;
  logic             scan_done;
  logic             elig;
  logic             hit;
  logic signed [9:0] nice_sum;
  logic [TICKETS_W-1:0] nice_tk;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign req_idx  = IDX_W'(item.slot);
  assign has_req  = !item.keep_requester;
  assign in_range = {26'd0, item.slot} < SLOT_COUNT;
  assign rd_entry = vld_q ? mem_q : '0;
  assign scan_done = (cnt == CNT_END) && !rd_pend;
  assign elig = rd_pend && rd_entry.in_lottery && !(has_req && rd_idx == req_idx);
  assign hit  = elig && (which < TOT_W'(rd_entry.tickets));

  // nice arithmetic with clamp
  assign nice_sum = $signed({3'b000, rd_entry.tickets})
                  + $signed({{2{item.nice_delta[7]}}, item.nice_delta});
  always_comb begin
    priority if (nice_sum > $signed({3'b000, MAX_TICKETS})) begin
      nice_tk = MAX_TICKETS;
    end else if (nice_sum < $signed({3'b000, MIN_TICKETS})) begin
      nice_tk = MIN_TICKETS;
    end else begin
      nice_tk = nice_sum[TICKETS_W-1:0];
    end
  end

  lts_rem_unit #(
    .DIV_W (TOT_W)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (item.random_value),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!in_range) begin
          state_next = ST_IDLE;
        end else begin
          unique case (item.cmd)
            CMD_START:   state_next = item.is_system_proc ? ST_IDLE : ST_EM_ONE;
            CMD_STOP:    state_next = ST_IDLE;
            CMD_NICE:    state_next = ST_NICE_RD;
            CMD_QUANTUM: state_next = ST_SUM;
          endcase
        end
      end
      ST_NICE_RD: state_next = ST_NICE_WR;
      ST_NICE_WR: state_next = ST_IDLE;
      ST_SUM: begin
        if (scan_done) begin
          priority if (total != '0) state_next = ST_DIV;
          else if (has_req && req_lot) state_next = ST_EM_ONE;
          else state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (hit || scan_done) state_next = ST_EM_REQ;
      end
      ST_EM_REQ: begin
        if (!(has_req && req_lot) || out_free) state_next = ST_EM_PREV;
      end
      ST_EM_PREV: begin
        if (!(winner_valid && winner_slot != win_idx) || out_free) state_next = ST_EM_WIN;
      end
      ST_EM_WIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_EM_ONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = req_idx;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = cnt[IDX_W-1:0];
    div_start = 1'b0;
    out_load  = 1'b0;
    ld_slot   = req_idx;
    ld_queue  = unlucky_queue;
    ld_last   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = !rst;
      ST_DECODE: begin
        if (in_range && item.cmd == CMD_START) begin
          mem_we = 1'b1;
          mem_wd.in_use     = 1'b1;
          mem_wd.in_lottery = !item.is_system_proc;
          mem_wd.tickets    = item.is_system_proc ? '0 : START_TICKETS;
        end else if (in_range && item.cmd == CMD_STOP) begin
          mem_we = 1'b1;
        end
      end
      ST_NICE_RD: begin
        mem_re = 1'b1;
        mem_ra = req_idx;
      end
      ST_NICE_WR: begin
        mem_we = rd_entry.in_lottery;
        mem_wd.in_use     = rd_entry.in_use;
        mem_wd.in_lottery = 1'b1;
        mem_wd.tickets    = nice_tk;
      end
      ST_SUM: begin
        mem_re    = cnt < CNT_END;
        div_start = scan_done && (total != '0);
      end
      ST_DIV: ;
      ST_WALK: begin
        mem_re = (cnt < CNT_END) && !hit;
      end
      ST_EM_REQ: begin
        out_load = has_req && req_lot && out_free;
      end
      ST_EM_PREV: begin
        out_load = winner_valid && (winner_slot != win_idx) && out_free;
        ld_slot  = winner_slot;
      end
      ST_EM_WIN: begin
        out_load = out_free;
        ld_slot  = win_idx;
        ld_queue = lucky_queue;
        ld_last  = 1'b1;
      end
      ST_EM_ONE: begin
        out_load = out_free;
        ld_queue = em_queue;
        ld_last  = 1'b1;
      end
      default: ;
    endcase
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      mem_q <= mem[mem_ra];
      vld_q <= vld[mem_ra];
    end
  end

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_wa] <= 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lucky_queue   <= LUCKY_RESET;
      unlucky_queue <= UNLUCKY_RESET;
      slice_len     <= SLICE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LUCKY:   lucky_queue   <= cfg_wdata[3:0];
        CFG_UNLUCKY: unlucky_queue <= cfg_wdata[3:0];
        CFG_SLICE:   slice_len     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state and winner memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      winner_valid <= 1'b0;
      winner_slot  <= '0;
      rd_pend      <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_re && (state == ST_SUM || state == ST_WALK);
      if (state == ST_DECODE && in_range && item.cmd == CMD_STOP
          && winner_valid && winner_slot == req_idx) begin
        winner_valid <= 1'b0;
      end
      if (state == ST_EM_WIN && out_free) begin
        winner_valid <= 1'b1;
        winner_slot  <= win_idx;
      end
    end
  end

  // item capture and draw datapath
  always_ff @(posedge clk) begin
    if (in_xfer) item <= in_data;
    if (mem_re) rd_idx <= mem_ra;
    unique case (state)
      ST_DECODE: begin
        cnt      <= '0;
        total    <= '0;
        req_lot  <= 1'b0;
        em_queue <= unlucky_queue;
      end
      ST_SUM: begin
        if (mem_re) cnt <= cnt + 1'b1;
        if (elig) total <= total + TOT_W'(rd_entry.tickets);
        if (rd_pend && rd_idx == req_idx) req_lot <= rd_entry.in_lottery;
        em_queue <= lucky_queue;
      end
      ST_DIV: begin
        cnt <= '0;
        if (div_done) which <= div_rem;
      end
      ST_WALK: begin
        if (mem_re) cnt <= cnt + 1'b1;
        if (hit) win_idx <= rd_idx;
        else if (elig) which <= which - TOT_W'(rd_entry.tickets);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.target_slot  <= 6'(ld_slot);
      out_data.queue_number <= ld_queue;
      out_data.quantum      <= slice_len;
      out_data.last_of_run  <= ld_last;
    end
  end

  // checks
  `LTS_ASSERT_IMP(a_no_overwrite, clk, rst, out_load, !out_valid || out_ready)
  `LTS_ASSERT_IMP(a_one_port_use, clk, rst, mem_we, !mem_re)
  `LTS_ASSERT_IMP(a_div_in_wait, clk, rst, div_done, state == ST_DIV)
  `LTS_ASSERT_NEXT(a_winner_kept, clk, rst, state == ST_EM_WIN && out_load, winner_valid)

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for the lottery scheduler, checked against a slot-table predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;

  localparam int SLOTS         = 64;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 110;

  typedef enum {STALL_NONE, STALL_COIN, STALL_LONG} stall_mode_t;

  // slot table tracker: predicts queue assignments and checks them in order
  class lottery_board;
    logic                 in_use     [SLOTS];
    logic                 in_lottery [SLOTS];
    logic [TICKETS_W-1:0] tickets    [SLOTS];
    bit                   holder_valid;
    logic [5:0]           holder_slot;
    logic [3:0]           lucky;
    logic [3:0]           unlucky;
    logic [15:0]          slice;
    lts_out_t             pending_assignments[$];
    int                   mismatches;
    int                   checked;
    int                   cmd_count[4];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]     = 1'b0;
        in_lottery[i] = 1'b0;
        tickets[i]    = '0;
      end
      holder_valid = 1'b0;
      holder_slot  = '0;
      lucky        = LUCKY_RESET;
      unlucky      = UNLUCKY_RESET;
      slice        = SLICE_RESET;
      mismatches   = 0;
      checked      = 0;
      for (int i = 0; i < 4; i++) cmd_count[i] = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_LUCKY:   lucky   = value[3:0];
        CFG_UNLUCKY: unlucky = value[3:0];
        CFG_SLICE:   slice   = value;
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending_assignments.size();
    endfunction

    function void add_assignment(logic [5:0] target, logic [3:0] queue);
      lts_out_t a;
      a.target_slot  = target;
      a.queue_number = queue;
      a.quantum      = slice;
      a.last_of_run  = 1'b0;
      pending_assignments.push_back(a);
    endfunction

    function bit eligible(int i, bit has_req, logic [5:0] req);
      return in_lottery[i] && !(has_req && i == int'(req));
    endfunction

    // apply one accepted request; returns 0 for a nice on a slot outside the lottery, which the block ignores
    function bit note_request(lts_in_t r);
      int          queued_earlier;
      int          level;
      int unsigned total;
      int unsigned which;
      logic [5:0]  win;
      bit          has_req;
      bit          effective;
      lts_out_t    tail;
      queued_earlier = pending_assignments.size();
      effective      = 1'b1;
      cmd_count[r.cmd]++;
      case (r.cmd)
        CMD_START: begin
          in_use[r.slot] = 1'b1;
          if (r.is_system_proc) begin
            in_lottery[r.slot] = 1'b0;
            tickets[r.slot]    = '0;
          end else begin
            in_lottery[r.slot] = 1'b1;
            tickets[r.slot]    = START_TICKETS;
            add_assignment(r.slot, unlucky);
          end
        end
        CMD_STOP: begin
          in_use[r.slot]     = 1'b0;
          in_lottery[r.slot] = 1'b0;
          tickets[r.slot]    = '0;
          if (holder_valid && holder_slot == r.slot) holder_valid = 1'b0;
        end
        CMD_NICE: begin
          if (in_lottery[r.slot]) begin
            level = int'(tickets[r.slot]) + int'($signed(r.nice_delta));
            if (level > int'(MAX_TICKETS)) level = int'(MAX_TICKETS);
            else if (level < int'(MIN_TICKETS)) level = int'(MIN_TICKETS);
            tickets[r.slot] = level[TICKETS_W-1:0];
          end else begin
            effective = 1'b0;
          end
        end
        default: begin
          // quantum expiry: draw over the eligible lottery slots
          has_req = !r.keep_requester;
          total   = 0;
          for (int i = 0; i < SLOTS; i++)
            if (eligible(i, has_req, r.slot)) total += tickets[i];
          if (total != 0) begin
            which = r.random_value % total;
            win   = '0;
            if (has_req && in_lottery[r.slot]) add_assignment(r.slot, unlucky);
            for (int i = 0; i < SLOTS; i++) begin
              if (eligible(i, has_req, r.slot)) begin
                if (which < tickets[i]) begin
                  win = i[5:0];
                  break;
                end
                which -= tickets[i];
              end
            end
            if (holder_valid && holder_slot != win) add_assignment(holder_slot, unlucky);
            add_assignment(win, lucky);
            holder_valid = 1'b1;
            holder_slot  = win;
          end else if (has_req && in_lottery[r.slot]) begin
            add_assignment(r.slot, lucky);
          end
        end
      endcase
      // flag the final assignment of this request
      if (pending_assignments.size() > queued_earlier) begin
        tail = pending_assignments[pending_assignments.size()-1];
        tail.last_of_run = 1'b1;
        pending_assignments[pending_assignments.size()-1] = tail;
      end
      return effective;
    endfunction

    function void check_assignment(lts_out_t got);
      lts_out_t want;
      checked++;
      if (pending_assignments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected assignment slot %0d queue %0d quantum %0d last %0b",
                   $time, got.target_slot, got.queue_number, got.quantum, got.last_of_run);
        return;
      end
      want = pending_assignments.pop_front();
      if (got.target_slot !== want.target_slot || got.queue_number !== want.queue_number ||
          got.quantum !== want.quantum || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected slot %0d queue %0d quantum %0d last %0b, got %0d %0d %0d %0b",
                   $time, want.target_slot, want.queue_number, want.quantum,
                   want.last_of_run, got.target_slot, got.queue_number, got.quantum,
                   got.last_of_run);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  lts_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lts_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = CFG_LUCKY;
  logic [15:0] cfg_wdata = '0;

  stall_mode_t  stall_mode  = STALL_NONE;
  int           stall_left  = 0;
  int           cycle_count = 0;
  lottery_board board       = new();

  lottery_scheduler #(.SLOT_COUNT(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_ready <= 1'b1;
        STALL_COIN: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 24);
        end
      endcase
    end
  end

  // result transfers go to the tracker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_assignment(out_data);
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic lts_in_t make_request(lts_cmd_t cmd, int slot, bit sys, int delta,
                                           bit keep, logic [29:0] rv);
    lts_in_t r;
    r.cmd            = cmd;
    r.slot           = slot[5:0];
    r.is_system_proc = sys;
    r.nice_delta     = delta[7:0];
    r.keep_requester = keep;
    r.random_value   = rv;
    return r;
  endfunction

  // random request, mostly on a small pool of slots so the draw sees many players
  function automatic lts_in_t random_request();
    lts_in_t     r;
    int unsigned pick;
    logic [31:0] rv;
    int          delta;
    pick = $urandom_range(0, 99);
    rv   = $urandom();
    if (pick < 28)      r.cmd = CMD_START;
    else if (pick < 38) r.cmd = CMD_STOP;
    else if (pick < 63) r.cmd = CMD_NICE;
    else                r.cmd = CMD_QUANTUM;
    r.slot           = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 11));
    r.is_system_proc = ($urandom_range(0, 4) == 0);
    delta            = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 200)) - 100
                                                   : int'($urandom_range(0, 20)) - 10;
    r.nice_delta     = delta[7:0];
    r.keep_requester = ($urandom_range(0, 3) == 0);
    r.random_value   = ($urandom_range(0, 1) == 0) ? rv[29:0] : 30'($urandom_range(0, 500));
    return r;
  endfunction

  // hold the request until its transfer
  task automatic send_request(input lts_in_t r, output bit took);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    took = board.note_request(r);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.pending_count() != 0);
  endtask

  // drain, then let any result-free request finish before touching registers
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [3:0] lucky, input logic [3:0] unlucky,
                                   input logic [15:0] slice);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LUCKY;
    cfg_wdata <= {12'h000, lucky};
    @(posedge clk);
    board.set_register(CFG_LUCKY, {12'h000, lucky});
    cfg_addr  <= CFG_UNLUCKY;
    cfg_wdata <= {12'h000, unlucky};
    @(posedge clk);
    board.set_register(CFG_UNLUCKY, {12'h000, unlucky});
    cfg_addr  <= CFG_SLICE;
    cfg_wdata <= slice;
    @(posedge clk);
    board.set_register(CFG_SLICE, slice);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int target, input bit gaps, input int pause_at);
    int done;
    int burst;
    bit took;
    bit paused;
    done   = 0;
    paused = 1'b0;
    burst  = $urandom_range(1, 8);
    while (done < target) begin
      send_request(random_request(), took);
      if (took) done++;
      if (!paused && done == pause_at) begin
        // hold off until every outstanding assignment has come out
        paused = 1'b1;
        in_valid <= 1'b0;
        wait_drained();
      end else if (gaps) begin
        burst--;
        if (burst == 0) begin
          in_valid <= 1'b0;
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6))
            @(posedge clk);
          burst = $urandom_range(1, 8);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_directed();
    lts_in_t list[$];
    bit      took;
    // empty table, then system and user starts
    list.push_back(make_request(CMD_QUANTUM, 5, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_START, 63, 1'b1, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_START, 0, 1'b0, 0, 1'b0, 30'd0));
    // requester alone in the lottery gets the lucky queue
    list.push_back(make_request(CMD_QUANTUM, 0, 1'b0, 0, 1'b0, 30'h3FFFFFFF));
    list.push_back(make_request(CMD_START, 1, 1'b0, 0, 1'b0, 30'd0));
    // nice clamps at both ends, nice on system and unused slots
    list.push_back(make_request(CMD_NICE, 1, 1'b0, 100, 1'b0, 30'd0));
    list.push_back(make_request(CMD_NICE, 0, 1'b0, -100, 1'b0, 30'd0));
    list.push_back(make_request(CMD_NICE, 63, 1'b0, 50, 1'b0, 30'd0));
    list.push_back(make_request(CMD_NICE, 10, 1'b0, -1, 1'b0, 30'd0));
    // draws: requester demoted, previous winner demoted, requester also previous winner
    list.push_back(make_request(CMD_QUANTUM, 0, 1'b0, 0, 1'b0, 30'h3FFFFFFF));
    list.push_back(make_request(CMD_QUANTUM, 1, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_QUANTUM, 5, 1'b0, 0, 1'b1, 30'd0));
    // restart of a running slot, then stop of the remembered winner
    list.push_back(make_request(CMD_START, 0, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_STOP, 0, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_QUANTUM, 63, 1'b0, 0, 1'b0, 30'd12345));
    // system slot becomes a user slot and the other way round
    list.push_back(make_request(CMD_START, 63, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_START, 1, 1'b1, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_QUANTUM, 63, 1'b0, 0, 1'b0, 30'h2AAAAAAA));
    list.push_back(make_request(CMD_STOP, 63, 1'b0, 0, 1'b0, 30'd0));
    list.push_back(make_request(CMD_QUANTUM, 63, 1'b0, 0, 1'b1, 30'h15555555));
    foreach (list[i]) send_request(list[i], took);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset register values
    stall_mode <= STALL_COIN;
    run_directed();
    settle();

    // extremes one way, bursty sender, coin-flip stalls
    program_registers(4'd0, 4'd15, 16'hFFFF);
    run_phase(PHASE_ITEMS, 1'b1, PHASE_ITEMS / 2);
    settle();

    // extremes the other way, no idling on either side
    program_registers(4'd15, 4'd0, 16'd1);
    stall_mode <= STALL_NONE;
    run_phase(PHASE_ITEMS, 1'b0, 0);
    settle();

    // zero slice passes through, long receiver stalls
    program_registers(4'd5, 4'd10, 16'd0);
    stall_mode <= STALL_LONG;
    run_phase(PHASE_ITEMS, 1'b1, 0);
    settle();

    // random setting
    program_registers(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      16'($urandom_range(1, 65535)));
    stall_mode <= STALL_COIN;
    run_phase(PHASE_ITEMS, 1'b1, PHASE_ITEMS / 3);
    settle();

    $display("requests: %0d start, %0d stop, %0d nice, %0d quantum expiry; %0d assignments",
             board.cmd_count[CMD_START], board.cmd_count[CMD_STOP],
             board.cmd_count[CMD_NICE], board.cmd_count[CMD_QUANTUM], board.checked);
    $display("five register settings, queue and slice extremes included; %0d mismatches",
             board.mismatches);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
